@@ sv/utf8_topic_validator_top_macros.svh @@
// ----------------------------------------------------------------------------
// utf8_topic_validator_top_macros.svh
// Assertion macros shared by the validator RTL. Clock aclk, reset aresetn.
// ----------------------------------------------------------------------------
`ifndef UTF8_TOPIC_VALIDATOR_TOP_MACROS_SVH
`define UTF8_TOPIC_VALIDATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define UTV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define UTV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UTV_ASSERT_IMPL(label, ante, cons)
`define UTV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/utf8tv_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8tv_pkg
// Types and constants for the UTF-8 topic validator.
// ----------------------------------------------------------------------------
package utf8tv_pkg;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_TOO_LONG  = 4'd1,
        ERR_BAD_LEAD  = 4'd2,
        ERR_BAD_CONT  = 4'd3,
        ERR_TRUNCATED = 4'd4,
        ERR_OVERLONG  = 4'd5,
        ERR_SURROGATE = 4'd6,
        ERR_CONTROL   = 4'd7,
        ERR_NONCHAR   = 4'd8,
        ERR_WILDCARD  = 4'd9
    } err_kind_t;

    typedef enum logic [1:0] {
        CFG_LOW_PRINTABLE  = 2'd0,
        CFG_HIGH_PRINTABLE = 2'd1,
        CFG_MAX_LENGTH     = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    localparam logic [6:0]  LOW_PRINTABLE_RST  = 7'd32;
    localparam logic [6:0]  HIGH_PRINTABLE_RST = 7'd126;
    localparam logic [15:0] MAX_LENGTH_RST     = 16'hFFFF;
    localparam logic [16:0] COUNT_MAX          = 17'h1FFFF;

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;

    typedef struct packed {
        logic [6:0]  low_printable;
        logic [6:0]  high_printable;
        logic [15:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic      valid_res;
        err_kind_t error_kind;
    } result_t;

    // Checks on a fully decoded multi-byte code point.
    function automatic err_kind_t check_code_point(input logic [20:0] cp,
                                                   input logic [2:0]  seq_len);
        err_kind_t res;
        res = ERR_NONE;
        if ((seq_len == 3'd2 && cp < 21'h80) || (seq_len == 3'd3 && cp < 21'h800) ||
            (seq_len == 3'd4 && cp < 21'h10000)) begin
            res = ERR_OVERLONG;
        end else if (cp inside {[21'h00D800:21'h00DFFF]}) begin
            res = ERR_SURROGATE;
        end else if (cp inside {[21'h00007F:21'h00009F]}) begin
            res = ERR_CONTROL;
        end else if (cp inside {[21'h00FDD0:21'h00FDEF]}) begin
            res = ERR_NONCHAR;
        end else if (cp[20:16] <= 5'd16 && cp[15:1] == 15'h7FFF) begin
            // U+xFFFE / U+xFFFF in planes 0..16
            res = ERR_NONCHAR;
        end
        return res;
    endfunction

endpackage

@@ sv/utf8tv_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// utf8tv_cfg_regs
// Configuration register file: printable bounds and length limit.
// ----------------------------------------------------------------------------
module utf8tv_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [1:0]                         wr_index,
    input  logic [utf8tv_pkg::CFG_DATA_W-1:0]  wr_data,
    output utf8tv_pkg::cfg_t                   cfg
);

    utf8tv_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_printable  <= utf8tv_pkg::LOW_PRINTABLE_RST;
            cfg_reg.high_printable <= utf8tv_pkg::HIGH_PRINTABLE_RST;
            cfg_reg.max_length     <= utf8tv_pkg::MAX_LENGTH_RST;
        end else if (wr_en) begin
            case (utf8tv_pkg::cfg_index_t'(wr_index))
                utf8tv_pkg::CFG_LOW_PRINTABLE:  cfg_reg.low_printable  <= wr_data[6:0];
                utf8tv_pkg::CFG_HIGH_PRINTABLE: cfg_reg.high_printable <= wr_data[6:0];
                utf8tv_pkg::CFG_MAX_LENGTH:     cfg_reg.max_length     <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/utf8tv_core.sv @@
// ----------------------------------------------------------------------------
// utf8tv_core
// Per-string decode state and the one-byte check/update step.
// ----------------------------------------------------------------------------
`include "utf8_topic_validator_top_macros.svh"

module utf8tv_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           data_byte,
    input  logic                 forbid_wildcards,
    input  logic                 last_byte,
    input  utf8tv_pkg::cfg_t     cfg,
    output utf8tv_pkg::result_t  result
);

    logic [1:0]              pending_reg,  pending_next;
    logic [2:0]              seq_len_reg,  seq_len_next;
    logic [20:0]             acc_reg,      acc_next;
    utf8tv_pkg::err_kind_t   first_reg,    first_next;
    logic [16:0]             count_reg,    count_next;

    logic [1:0]              pend_dec;
    logic [20:0]             acc_merged;
    logic                    too_long;
    utf8tv_pkg::err_kind_t   byte_err;
    utf8tv_pkg::err_kind_t   step_err;
    logic [1:0]              pend_step;
    logic [2:0]              seq_step;
    logic [20:0]             acc_step;

    assign count_next = (count_reg != utf8tv_pkg::COUNT_MAX) ? count_reg + 17'd1 : count_reg;
    assign too_long   = count_next > {1'b0, cfg.max_length};
    assign pend_dec   = pending_reg - 2'd1;

    always_comb begin
        case (pend_dec)
            2'd2:    acc_merged = acc_reg | {3'd0, data_byte[5:0], 12'd0};
            2'd1:    acc_merged = acc_reg | {9'd0, data_byte[5:0], 6'd0};
            default: acc_merged = acc_reg | {15'd0, data_byte[5:0]};
        endcase
    end

    // byte content checks and decode state update
    always_comb begin
        byte_err  = utf8tv_pkg::ERR_NONE;
        pend_step = pending_reg;
        seq_step  = seq_len_reg;
        acc_step  = acc_reg;
        if (pending_reg != 2'd0) begin
            if (data_byte[7:6] != 2'b10) begin
                byte_err  = utf8tv_pkg::ERR_BAD_CONT;
                pend_step = 2'd0;
                seq_step  = 3'd0;
                acc_step  = '0;
            end else if (pend_dec == 2'd0) begin
                byte_err  = utf8tv_pkg::check_code_point(acc_merged, seq_len_reg);
                pend_step = 2'd0;
                seq_step  = 3'd0;
                acc_step  = '0;
            end else begin
                pend_step = pend_dec;
                acc_step  = acc_merged;
            end
        end else if (!data_byte[7]) begin
            if (forbid_wildcards &&
                (data_byte == utf8tv_pkg::CHAR_HASH || data_byte == utf8tv_pkg::CHAR_PLUS)) begin
                byte_err = utf8tv_pkg::ERR_WILDCARD;
            end else if (data_byte[6:0] < cfg.low_printable ||
                         data_byte[6:0] > cfg.high_printable) begin
                byte_err = utf8tv_pkg::ERR_CONTROL;
            end
        end else if (data_byte[7:5] == 3'b110) begin
            pend_step = 2'd1;
            seq_step  = 3'd2;
            acc_step  = {10'd0, data_byte[4:0], 6'd0};
        end else if (data_byte[7:4] == 4'b1110) begin
            pend_step = 2'd2;
            seq_step  = 3'd3;
            acc_step  = {5'd0, data_byte[3:0], 12'd0};
        end else if (data_byte[7:3] == 5'b11110) begin
            pend_step = 2'd3;
            seq_step  = 3'd4;
            acc_step  = {data_byte[2:0], 18'd0};
        end else begin
            byte_err = utf8tv_pkg::ERR_BAD_LEAD;
        end
    end

    // error priority within one byte: length, content, truncation
    always_comb begin
        if (too_long) begin
            step_err = utf8tv_pkg::ERR_TOO_LONG;
        end else if (byte_err != utf8tv_pkg::ERR_NONE) begin
            step_err = byte_err;
        end else if (last_byte && pend_step != 2'd0) begin
            step_err = utf8tv_pkg::ERR_TRUNCATED;
        end else begin
            step_err = utf8tv_pkg::ERR_NONE;
        end
        first_next   = (first_reg != utf8tv_pkg::ERR_NONE) ? first_reg : step_err;
        pending_next = pend_step;
        seq_len_next = seq_step;
        acc_next     = acc_step;
    end

    assign result.valid_res  = (first_next == utf8tv_pkg::ERR_NONE);
    assign result.error_kind = first_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            seq_len_reg <= 3'd0;
            acc_reg     <= '0;
            first_reg   <= utf8tv_pkg::ERR_NONE;
            count_reg   <= '0;
        end else if (step_en) begin
            if (last_byte) begin
                pending_reg <= 2'd0;
                seq_len_reg <= 3'd0;
                acc_reg     <= '0;
                first_reg   <= utf8tv_pkg::ERR_NONE;
                count_reg   <= '0;
            end else begin
                pending_reg <= pending_next;
                seq_len_reg <= seq_len_next;
                acc_reg     <= acc_next;
                first_reg   <= first_next;
                count_reg   <= count_next;
            end
        end
    end

    // a sequence in flight always has a length, and only then
    `UTV_ASSERT_IMPL(a_seq_consistent, 1'b1, (pending_reg == 2'd0) == (seq_len_reg == 3'd0))
    // continuation count never exceeds what the lead announced
    `UTV_ASSERT_IMPL(a_pending_bound, pending_reg != 2'd0, {1'b0, pending_reg} < seq_len_reg)
    // a final byte leaves the string state cleared
    `UTV_ASSERT_NEXT(a_clear_on_last, step_en && last_byte,
                     count_reg == 17'd0 && pending_reg == 2'd0 &&
                     first_reg == utf8tv_pkg::ERR_NONE)

endmodule

@@ sv/utf8_topic_validator_top.sv @@
// ----------------------------------------------------------------------------
// utf8_topic_validator_top
// Strict UTF-8 validator for topic strings, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one byte of a string per transaction, with s_last_byte on the
//   final byte and s_forbid_wildcards to reject '#' and '+'. Empty strings are
//   never presented.
//   m_* channel: one transaction per string, issued for its last byte, carrying
//   m_valid_res and the first error found (m_error_kind, 0 when clean).
//   cfg_* channel: register writes (0 low bound, 1 high bound, 2 max length),
//   always ready; write only while no string is in flight.
// Timing: a byte is checked while it sits in the input register; the core state
//   and the result register load as it moves on, so the result is registered
//   from the input register holding the last byte. Throughput is one byte per
//   cycle, save while a final byte waits on the result slot (see Stall).
// Stall: while a result waits on m_ready, non-final bytes keep flowing; a final
//   byte waits in the input register and s_ready drops behind it.
// Reset (aresetn low, synchronous): registers take their defaults, string
//   state clears and both valid flags drop.
// ----------------------------------------------------------------------------
`include "utf8_topic_validator_top_macros.svh"

module utf8_topic_validator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // byte input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_forbid_wildcards,
    input  logic                               s_last_byte,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_valid_res,
    output logic [3:0]                         m_error_kind,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [utf8tv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    utf8tv_pkg::cfg_t     cfg;
    utf8tv_pkg::result_t  result;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_forbid_reg;
    logic        in_last_reg;

    // result register
    logic        m_valid_reg;
    logic        m_valid_res_reg;
    logic [3:0]  m_error_kind_reg;

    logic        advance;

    assign cfg_ready = 1'b1;

    utf8tv_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The held byte moves on unless it is a final byte and the result slot is
    // still occupied by an untaken transaction.
    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg   <= s_data_byte;
            in_forbid_reg <= s_forbid_wildcards;
            in_last_reg   <= s_last_byte;
        end
    end

    utf8tv_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (advance),
        .data_byte        (in_byte_reg),
        .forbid_wildcards (in_forbid_reg),
        .last_byte        (in_last_reg),
        .cfg              (cfg),
        .result           (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_valid_res_reg  <= result.valid_res;
            m_error_kind_reg <= result.error_kind;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_valid_res  = m_valid_res_reg;
    assign m_error_kind = m_error_kind_reg;

    // a completed string always produces a result transaction next cycle
    `UTV_ASSERT_NEXT(a_result_follows_last, advance && in_last_reg, m_valid_reg)
    // a held byte that cannot move stays in the input register
    `UTV_ASSERT_NEXT(a_hold_when_blocked, in_valid_reg && !advance,
                     in_valid_reg && in_last_reg)
    // the flag and the code of a result agree
    `UTV_ASSERT_IMPL(a_flag_matches_code, m_valid_reg,
                     m_valid_res_reg == (m_error_kind_reg == utf8tv_pkg::ERR_NONE))

endmodule
